### sv/pssnf_pkg.sv
// Package with shared types and codes for the point slot store.
`timescale 1ns / 1ps
package pssnf_pkg;

   typedef enum logic [3:0] {
      OP_PUSH_TOP    = 4'd0,
      OP_POP_TOP     = 4'd1,
      OP_PUSH_BOTTOM = 4'd2,
      OP_POP_BOTTOM  = 4'd3,
      OP_COUNT       = 4'd4,
      OP_CLEAR       = 4'd5,
      OP_FARTHEST    = 4'd6,
      OP_NEAREST     = 4'd7,
      OP_SORT        = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIST,
      S_SCAN,
      S_SCAN_WAIT,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_WRITE,
      S_FETCH,
      S_FETCH_WAIT,
      S_SORT_RD,
      S_SORT_WR,
      S_SORT_EMIT,
      S_EMIT_WAIT
   } state_type;

   // One stored entry: point and its squared distance.
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [31:0]        dist_sq;
   } entry_type;

endpackage

### sv/pssnf_mem.sv
// Synchronous slot memory with one write port and one registered read port.
`timescale 1ns / 1ps
module pssnf_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  pssnf_pkg::entry_type wr_data,
   input  logic [AW-1:0]        rd_addr,
   output pssnf_pkg::entry_type rd_data
);
   import pssnf_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/pssnf_dist.sv
// Squared distance unit: squares registered, then summed combinationally.
`timescale 1ns / 1ps
module pssnf_dist (
   input  logic               clock,
   input  logic signed [15:0] x,
   input  logic signed [15:0] y,
   input  logic signed [15:0] z,
   output logic [31:0]        dist_sq
);
   logic [31:0] sq_x_ff, sq_y_ff, sq_z_ff;

   always_ff @(posedge clock) begin
      sq_x_ff <= 32'(x * x);
      sq_y_ff <= 32'(y * y);
      sq_z_ff <= 32'(z * z);
   end

   assign dist_sq = sq_x_ff + sq_y_ff + sq_z_ff;
endmodule

### sv/point_slot_store_nearest_farthest_unit.sv
// Top level of the point slot store with nearest, farthest and sort queries.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-----------------------
//   request | req_op, req_coord_x/y/z                 | start high, busy low
//   result  | rsp_out_x/y/z, rsp_out_dist_sq, ...     | rsp_valid, one cycle
//
// One item at a time. Count, clear, unknown codes, refused pushes and queries
// on an empty store answer straight from idle; a top push computes the
// squared distance and writes the entry, and a pop fetches its entry. A bottom
// push first moves each entry below the lowest hole up by one slot, with a read
// and a write per entry. Farthest and nearest read every slot, then fetch the
// winner. A sort runs one pass per stored point: pass j scans slots j and up,
// reads the winner, rotates it down to slot j and writes it there.
// The controller issues one memory access per step, so accesses to one entry
// never overlap. Reset clears occupancy, count and state at once; entries are
// undefined until written, and the contents of free slots never reach a result.
// The result receiver cannot stall; busy stays high until the last result of
// an item has been shown.
`timescale 1ns / 1ps
module point_slot_store_nearest_farthest_unit #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_op,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [15:0] req_coord_z,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic [31:0]        rsp_out_dist_sq,
   output logic [4:0]         rsp_stored_points,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);
   import pssnf_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type         state_ff, state_in;
   logic [3:0]        op_ff, op_in;
   entry_type         pt_ff, pt_in;
   logic [CAPACITY-1:0] used_ff, used_in;
   logic [CW-1:0]     count_ff, count_in;
   // Scan pointer and best match for the query and sort passes.
   logic [AW-1:0]     scan_ff, scan_in;
   logic [AW-1:0]     best_ff, best_in;
   logic              best_ok_ff, best_ok_in;
   logic [31:0]       best_d_ff, best_d_in;
   // Target slot for pushes, pops and the moving entry of a shift.
   logic [AW-1:0]     slot_ff, slot_in;
   logic [CW-1:0]     out_n_ff, out_n_in;
   // Size of the sorted prefix; it is also the floor of a shift.
   logic [CW-1:0]     sorted_ff, sorted_in;

   logic              rsp_valid_ff, rsp_valid_in;
   entry_type         rsp_pt_ff, rsp_pt_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              mem_we;
   logic [AW-1:0]     mem_wa, mem_ra;
   entry_type         mem_wd, mem_rd;
   logic [31:0]       new_dist;

   pssnf_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_wa),
      .wr_data(mem_wd),
      .rd_addr(mem_ra),
      .rd_data(mem_rd)
   );

   pssnf_dist u_dist (
      .clock  (clock),
      .x      (pt_ff.x),
      .y      (pt_ff.y),
      .z      (pt_ff.z),
      .dist_sq(new_dist)
   );

   // Priority encoders over the occupancy bits.
   logic [AW-1:0] low_used, high_used, low_free;
   logic          any_used, any_free;
   logic [CW-1:0] top_idx;

   always_comb begin
      low_used  = '0;
      high_used = '0;
      low_free  = '0;
      any_used  = 1'b0;
      any_free  = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (used_ff[i]) begin
            low_used = AW'(i);
            any_used = 1'b1;
         end
         if (!used_ff[i]) begin
            low_free = AW'(i);
            any_free = 1'b1;
         end
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (used_ff[i]) begin
            high_used = AW'(i);
         end
      end
      top_idx = any_used ? CW'(high_used) + CW'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pt_ff         <= pt_in;
      scan_ff       <= scan_in;
      best_ff       <= best_in;
      best_ok_ff    <= best_ok_in;
      best_d_ff     <= best_d_in;
      slot_ff       <= slot_in;
      out_n_ff      <= out_n_in;
      sorted_ff     <= sorted_in;
      rsp_pt_ff     <= rsp_pt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pt_in         = pt_ff;
      used_in       = used_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      best_in       = best_ff;
      best_ok_in    = best_ok_ff;
      best_d_in     = best_d_ff;
      slot_in       = slot_ff;
      out_n_in      = out_n_ff;
      sorted_in     = sorted_ff;
      rsp_valid_in  = 1'b0;
      rsp_pt_in     = rsp_pt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_wa        = slot_ff;
      mem_wd        = pt_ff;
      mem_ra        = slot_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               pt_in.x  = req_coord_x;
               pt_in.y  = req_coord_y;
               pt_in.z  = req_coord_z;
               sorted_in     = '0;
               rsp_pt_in     = '0;
               rsp_status_in = ST_OK;
               rsp_last_in   = 1'b1;
               case (req_op)
                  OP_PUSH_TOP, OP_PUSH_BOTTOM: begin
                     if (count_ff >= CW'(CAPACITY) || !any_free) begin
                        rsp_status_in = ST_FULL;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_EMIT_WAIT;
                     end else if (req_op == OP_PUSH_TOP &&
                                  top_idx < CW'(CAPACITY)) begin
                        slot_in  = top_idx[AW-1:0];
                        state_in = S_DIST;
                     end else if (req_op == OP_PUSH_TOP) begin
                        slot_in  = low_free;
                        state_in = S_DIST;
                     end else begin
                        // Move entries below the lowest hole up by one.
                        slot_in  = low_free;
                        state_in = (low_free == '0) ? S_DIST : S_SHIFT_RD;
                     end
                  end
                  OP_POP_TOP, OP_POP_BOTTOM: begin
                     if (!any_used) begin
                        rsp_status_in = ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_EMIT_WAIT;
                     end else begin
                        slot_in  = (req_op == OP_POP_TOP) ? high_used : low_used;
                        used_in[(req_op == OP_POP_TOP) ? high_used : low_used] = 1'b0;
                        count_in = count_ff - CW'(1);
                        state_in = S_FETCH;
                     end
                  end
                  OP_CLEAR: begin
                     used_in      = '0;
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     state_in     = S_EMIT_WAIT;
                  end
                  OP_FARTHEST, OP_NEAREST, OP_SORT: begin
                     if (!any_used) begin
                        rsp_status_in = ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_EMIT_WAIT;
                     end else begin
                        scan_in    = '0;
                        best_ok_in = 1'b0;
                        out_n_in   = count_ff;
                        state_in   = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_EMIT_WAIT;
                  end
               endcase
            end
         end
         S_SHIFT_RD: begin
            mem_ra   = slot_ff - AW'(1);
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // The entry and its occupancy bit move up by one slot. The shift
            // stops once the slot just above the floor has been written.
            mem_we = 1'b1;
            mem_wa = slot_ff;
            mem_wd = mem_rd;
            used_in[slot_ff] = used_ff[slot_ff - AW'(1)];
            slot_in = slot_ff - AW'(1);
            if (slot_ff == sorted_ff[AW-1:0] + AW'(1)) begin
               state_in = (op_ff == OP_SORT) ? S_SORT_EMIT : S_DIST;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_DIST: begin
            // Squares are registered this cycle; the sum is ready next.
            state_in = S_WRITE;
         end
         S_WRITE: begin
            mem_we        = 1'b1;
            mem_wd        = pt_ff;
            mem_wd.dist_sq = new_dist;
            used_in[slot_ff] = 1'b1;
            count_in      = count_ff + CW'(1);
            rsp_pt_in     = mem_wd;
            rsp_valid_in  = 1'b1;
            state_in      = S_EMIT_WAIT;
         end
         S_FETCH: begin
            mem_ra   = slot_ff;
            state_in = S_FETCH_WAIT;
         end
         S_FETCH_WAIT: begin
            rsp_pt_in    = mem_rd;
            rsp_valid_in = 1'b1;
            state_in     = S_EMIT_WAIT;
         end
         S_SCAN: begin
            mem_ra   = scan_ff;
            state_in = S_SCAN_WAIT;
         end
         S_SCAN_WAIT: begin
            // Compare the entry read at the current scan address.
            if (used_ff[scan_ff]) begin
               if (!best_ok_ff ||
                   (op_ff == OP_FARTHEST ? mem_rd.dist_sq > best_d_ff
                                         : mem_rd.dist_sq < best_d_ff)) begin
                  best_ok_in = 1'b1;
                  best_in    = scan_ff;
                  best_d_in  = mem_rd.dist_sq;
               end
            end
            if (scan_ff == AW'(CAPACITY - 1)) begin
               slot_in  = best_in;
               if (op_ff == OP_SORT) begin
                  state_in = S_SORT_RD;
               end else begin
                  state_in = S_FETCH;
               end
            end else begin
               scan_in  = scan_ff + AW'(1);
               state_in = S_SCAN;
            end
         end
         S_SORT_RD: begin
            // Read the winner of this pass.
            mem_ra   = best_ff;
            state_in = S_SORT_WR;
         end
         S_SORT_WR: begin
            // Hold the winner while the entries between the sorted prefix and
            // its old slot move up by one, which keeps their order for ties.
            pt_in   = mem_rd;
            slot_in = best_ff;
            if (best_ff == sorted_ff[AW-1:0]) begin
               state_in = S_SORT_EMIT;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_SORT_EMIT: begin
            // The winner closes the sorted prefix and is shown as a result.
            mem_we = 1'b1;
            mem_wa = sorted_ff[AW-1:0];
            mem_wd = pt_ff;
            used_in[sorted_ff[AW-1:0]] = 1'b1;
            rsp_pt_in    = pt_ff;
            rsp_valid_in = 1'b1;
            rsp_last_in  = (sorted_ff + CW'(1) == out_n_ff);
            sorted_in    = sorted_ff + CW'(1);
            if (sorted_ff + CW'(1) == out_n_ff) begin
               state_in = S_EMIT_WAIT;
            end else begin
               state_in   = S_SCAN;
               scan_in    = AW'(sorted_ff + CW'(1));
               best_ok_in = 1'b0;
            end
         end
         S_EMIT_WAIT: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = rsp_pt_ff.x;
   assign rsp_out_y         = rsp_pt_ff.y;
   assign rsp_out_z         = rsp_pt_ff.z;
   assign rsp_out_dist_sq   = rsp_pt_ff.dist_sq;
   assign rsp_stored_points = 5'((op_ff == OP_SORT && rsp_status_ff == ST_OK)
                                 ? out_n_ff : count_ff);
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;
endmodule

### sv/pssnf_checker.sv
// Port-level checker for the point slot store, bound to the top level.
`timescale 1ns / 1ps
module pssnf_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [4:0] rsp_stored_points,
   input logic       rsp_last
);
   import pssnf_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after accept");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL ||
                     rsp_status == ST_EMPTY)) else $error("bad status code");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_stored_points == 5'd0 && rsp_last))
      else $error("empty status with points");
   a_full_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> rsp_last) else $error("full not last");
endmodule

bind point_slot_store_nearest_farthest_unit pssnf_checker u_pssnf_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_stored_points(rsp_stored_points), .rsp_last(rsp_last)
);
